@@ rtl/owm_pkg.sv @@
package owm_pkg;

    // Command codes on the cmd field
    localparam logic [2:0] CMD_TICK       = 3'd0;
    localparam logic [2:0] CMD_RESET      = 3'd1;
    localparam logic [2:0] CMD_WRITE_BIT  = 3'd2;
    localparam logic [2:0] CMD_READ_BIT   = 3'd3;
    localparam logic [2:0] CMD_WRITE_BYTE = 3'd4;
    localparam logic [2:0] CMD_READ_BYTE  = 3'd5;

    // Sequencer phases
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_RST_LOW  = 3'd1;
    localparam logic [2:0] PH_RST_WAIT = 3'd2;
    localparam logic [2:0] PH_RST_TAIL = 3'd3;
    localparam logic [2:0] PH_SLOT_LOW = 3'd4;
    localparam logic [2:0] PH_SLOT_REL = 3'd5;

    // Register indexes (byte address 4*index)
    localparam logic [2:0] REG_RESET_LOW     = 3'd0;
    localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [2:0] REG_W1_LOW        = 3'd3;
    localparam logic [2:0] REG_W1_HIGH       = 3'd4;
    localparam logic [2:0] REG_W0_LOW        = 3'd5;
    localparam logic [2:0] REG_W0_HIGH       = 3'd6;

    // Register reset values
    localparam logic [9:0] RESET_LOW_DEFAULT     = 10'd480;
    localparam logic [9:0] PRESENCE_WAIT_DEFAULT = 10'd70;
    localparam logic [9:0] RESET_TAIL_DEFAULT    = 10'd410;
    localparam logic [7:0] W1_LOW_DEFAULT        = 8'd5;
    localparam logic [7:0] W1_HIGH_DEFAULT       = 8'd55;
    localparam logic [7:0] W0_LOW_DEFAULT        = 8'd60;
    localparam logic [7:0] W0_HIGH_DEFAULT       = 8'd5;

    // Classified tick as it travels through the queue
    typedef struct packed {
        logic       start;
        logic       is_reset;
        logic       is_read;
        logic       is_byte;
        logic [7:0] tx;
        logic       level;
    } item_t;

    // Timing configuration seen by the sequencer
    typedef struct packed {
        logic [9:0] reset_low_us;
        logic [9:0] presence_wait_us;
        logic [9:0] reset_tail_us;
        logic [7:0] write_one_low_us;
        logic [7:0] write_one_high_us;
        logic [7:0] write_zero_low_us;
        logic [7:0] write_zero_high_us;
    } cfg_t;

    // Result of one tick
    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] rx_data;
        logic       rejected;
    } result_t;

    // A zero duration counts as one microsecond
    function automatic logic [9:0] at_least_one(input logic [9:0] v);
        return (v == 10'd0) ? 10'd1 : v;
    endfunction

endpackage

@@ rtl/owm_front.sv @@
module owm_front
    import owm_pkg::*;
(
    input  logic [2:0] cmd,
    input  logic [7:0] tx_data,
    input  logic       line_level,
    output item_t      item
);

    // Classify the command and prepare the byte to send
    always_comb
    begin
        item          = '0;
        item.level    = line_level;
        unique case (cmd)
            CMD_RESET:
            begin
                item.start    = 1'b1;
                item.is_reset = 1'b1;
            end
            CMD_WRITE_BIT:
            begin
                item.start = 1'b1;
                item.tx    = {7'd0, tx_data[0]};
            end
            CMD_READ_BIT:
            begin
                item.start   = 1'b1;
                item.is_read = 1'b1;
            end
            CMD_WRITE_BYTE:
            begin
                item.start   = 1'b1;
                item.is_byte = 1'b1;
                item.tx      = tx_data;
            end
            CMD_READ_BYTE:
            begin
                item.start   = 1'b1;
                item.is_read = 1'b1;
                item.is_byte = 1'b1;
            end
            default:
            begin
                // plain tick, unused codes included
                item.start = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/owm_fifo.sv @@
module owm_fifo
    import owm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    item_t      entry_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_mem[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/owm_back.sv @@
module owm_back
    import owm_pkg::*;
#(
    parameter int READ_LOW_US    = 2,
    parameter int READ_SAMPLE_US = 10,
    parameter int READ_TAIL_US   = 50
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int READ_LOW_EFF    = (READ_LOW_US == 0) ? 1 : READ_LOW_US;
    localparam int READ_SAMPLE_EFF = (READ_SAMPLE_US == 0) ? 1 : READ_SAMPLE_US;
    localparam int READ_TAIL_EFF   = (READ_TAIL_US == 0) ? 1 : READ_TAIL_US;
    localparam int READ_REL_LEN    = READ_SAMPLE_EFF + READ_TAIL_EFF;

    logic [2:0] phase_reg, phase_next;
    logic [9:0] us_count_reg, us_count_next;
    logic [3:0] bits_left_reg, bits_left_next;
    logic [7:0] shift_reg, shift_next;
    logic       is_read_reg, is_read_next;
    logic       presence_reg, presence_next;
    logic       res_valid_reg;
    result_t    res_reg;
    result_t    res_next;
    logic       advance;
    logic [9:0] len;
    logic [10:0] count_inc;
    logic [2:0] pos;

    assign advance    = item_valid && (!res_valid_reg || res_ready);
    assign item_ready = !res_valid_reg || res_ready;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    // Step the sequencer by one microsecond
    always_comb
    begin
        phase_next     = phase_reg;
        us_count_next  = us_count_reg;
        bits_left_next = bits_left_reg;
        shift_next     = shift_reg;
        is_read_next   = is_read_reg;
        presence_next  = presence_reg;
        res_next       = '0;
        len            = 10'd1;
        count_inc      = 11'd0;
        pos            = 3'd0;

        // start a command, or flag it when busy
        if (phase_reg != PH_IDLE)
        begin
            res_next.rejected = item.start;
        end
        else if (item.start)
        begin
            us_count_next = 10'd0;
            if (item.is_reset)
            begin
                phase_next    = PH_RST_LOW;
                presence_next = 1'b0;
            end
            else
            begin
                phase_next     = PH_SLOT_LOW;
                is_read_next   = item.is_read;
                bits_left_next = item.is_byte ? 4'd8 : 4'd0;
                shift_next     = item.is_read ? 8'd0 : item.tx;
            end
        end

        if (phase_next != PH_IDLE)
        begin
            // length of the current phase
            unique case (phase_next)
                PH_RST_LOW:  len = at_least_one(cfg.reset_low_us);
                PH_RST_WAIT: len = at_least_one(cfg.presence_wait_us);
                PH_RST_TAIL: len = at_least_one(cfg.reset_tail_us);
                PH_SLOT_LOW:
                begin
                    if (is_read_next)
                        len = 10'(READ_LOW_EFF);
                    else if (shift_next[0])
                        len = at_least_one({2'd0, cfg.write_one_low_us});
                    else
                        len = at_least_one({2'd0, cfg.write_zero_low_us});
                end
                PH_SLOT_REL:
                begin
                    if (is_read_next)
                        len = 10'(READ_REL_LEN);
                    else if (shift_next[0])
                        len = at_least_one({2'd0, cfg.write_one_high_us});
                    else
                        len = at_least_one({2'd0, cfg.write_zero_high_us});
                end
                default: len = 10'd1;
            endcase

            res_next.drive_low = (phase_next == PH_RST_LOW) || (phase_next == PH_SLOT_LOW);
            count_inc = {1'b0, us_count_next} + 11'd1;

            // sample presence on the last microsecond of the wait
            if (phase_next == PH_RST_WAIT && count_inc >= {1'b0, len})
            begin
                presence_next = ~item.level;
            end

            // sample a read bit a fixed time after release
            if (phase_next == PH_SLOT_REL && is_read_next &&
                count_inc == 11'(READ_SAMPLE_EFF))
            begin
                pos = (bits_left_next == 4'd0) ? 3'd0 : 3'(4'd8 - bits_left_next);
                shift_next = shift_next | (8'(item.level) << pos);
            end

            us_count_next = count_inc[9:0];
            if (us_count_next >= len)
            begin
                us_count_next = 10'd0;
                unique case (phase_next)
                    PH_RST_LOW:  phase_next = PH_RST_WAIT;
                    PH_RST_WAIT: phase_next = PH_RST_TAIL;
                    PH_RST_TAIL:
                    begin
                        phase_next        = PH_IDLE;
                        res_next.done_res = 1'b1;
                    end
                    PH_SLOT_LOW: phase_next = PH_SLOT_REL;
                    default:
                    begin
                        if (!is_read_next)
                        begin
                            shift_next = shift_next >> 1;
                        end
                        if (bits_left_next <= 4'd1)
                        begin
                            bits_left_next    = 4'd0;
                            phase_next        = PH_IDLE;
                            res_next.done_res = 1'b1;
                        end
                        else
                        begin
                            bits_left_next = bits_left_next - 4'd1;
                            phase_next     = PH_SLOT_LOW;
                        end
                    end
                endcase
            end
        end

        res_next.busy_res = (phase_next != PH_IDLE);
        res_next.presence = presence_next;
        res_next.rx_data  = is_read_next ? shift_next : 8'd0;
    end

    // Hold sequencer state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            us_count_reg  <= 10'd0;
            bits_left_reg <= 4'd0;
            shift_reg     <= 8'd0;
            is_read_reg   <= 1'b0;
            presence_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg     <= phase_next;
                us_count_reg  <= us_count_next;
                bits_left_reg <= bits_left_next;
                shift_reg     <= shift_next;
                is_read_reg   <= is_read_next;
                presence_reg  <= presence_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

endmodule

@@ rtl/onewire_master_slot_engine_unit.sv @@
// One-wire bus master, stepped by one input transfer per microsecond tick. Each tick
// carries a command (reset/presence, write or read of a bit or a byte, LSB first) and
// the bus level sampled in that microsecond; each tick returns exactly one result
// transfer with the line drive, busy, done, presence, received data and a rejected
// flag for commands given while busy. The block takes one tick per clock cycle unless
// a side stalls: a tick is decoded on the way in, waits in a two-entry queue, and the
// sequencer updates its phase counter once per tick into the result register. Each
// tick is held in the queue, then its result in the result register. Queue and result
// register let either side stall without losing ticks. Timings are set through the APB
// registers (byte address 4*index) and should be changed only while no command runs.
module onewire_master_slot_engine_unit
    import owm_pkg::*;
#(
    parameter int READ_LOW_US    = 2,
    parameter int READ_SAMPLE_US = 10,
    parameter int READ_TAIL_US   = 50
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [7:0]  tx_data,
    input  logic        line_level,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        drive_low,
    output logic        busy_res,
    output logic        done_res,
    output logic        presence,
    output logic [7:0]  rx_data,
    output logic        rejected,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t    cfg_reg;
    item_t   front_item;
    item_t   queue_item;
    logic    queue_valid;
    logic    queue_ready;
    result_t res;
    logic    cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_us       <= RESET_LOW_DEFAULT;
            cfg_reg.presence_wait_us   <= PRESENCE_WAIT_DEFAULT;
            cfg_reg.reset_tail_us      <= RESET_TAIL_DEFAULT;
            cfg_reg.write_one_low_us   <= W1_LOW_DEFAULT;
            cfg_reg.write_one_high_us  <= W1_HIGH_DEFAULT;
            cfg_reg.write_zero_low_us  <= W0_LOW_DEFAULT;
            cfg_reg.write_zero_high_us <= W0_HIGH_DEFAULT;
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                REG_RESET_LOW:     cfg_reg.reset_low_us       <= pwdata[9:0];
                REG_PRESENCE_WAIT: cfg_reg.presence_wait_us   <= pwdata[9:0];
                REG_RESET_TAIL:    cfg_reg.reset_tail_us      <= pwdata[9:0];
                REG_W1_LOW:        cfg_reg.write_one_low_us   <= pwdata[7:0];
                REG_W1_HIGH:       cfg_reg.write_one_high_us  <= pwdata[7:0];
                REG_W0_LOW:        cfg_reg.write_zero_low_us  <= pwdata[7:0];
                REG_W0_HIGH:       cfg_reg.write_zero_high_us <= pwdata[7:0];
                default:           cfg_reg.reset_low_us       <= cfg_reg.reset_low_us;
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        unique case (paddr[4:2])
            REG_RESET_LOW:     prdata = {22'd0, cfg_reg.reset_low_us};
            REG_PRESENCE_WAIT: prdata = {22'd0, cfg_reg.presence_wait_us};
            REG_RESET_TAIL:    prdata = {22'd0, cfg_reg.reset_tail_us};
            REG_W1_LOW:        prdata = {24'd0, cfg_reg.write_one_low_us};
            REG_W1_HIGH:       prdata = {24'd0, cfg_reg.write_one_high_us};
            REG_W0_LOW:        prdata = {24'd0, cfg_reg.write_zero_low_us};
            REG_W0_HIGH:       prdata = {24'd0, cfg_reg.write_zero_high_us};
            default:           prdata = 32'd0;
        endcase
    end

    owm_front u_front (
        .cmd        (cmd),
        .tx_data    (tx_data),
        .line_level (line_level),
        .item       (front_item)
    );

    owm_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_item   (queue_item)
    );

    owm_back #(
        .READ_LOW_US    (READ_LOW_US),
        .READ_SAMPLE_US (READ_SAMPLE_US),
        .READ_TAIL_US   (READ_TAIL_US)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (queue_valid),
        .item_ready (queue_ready),
        .item       (queue_item),
        .res_valid  (out_valid),
        .res_ready  (out_ready),
        .res        (res)
    );

    assign drive_low = res.drive_low;
    assign busy_res  = res.busy_res;
    assign done_res  = res.done_res;
    assign presence  = res.presence;
    assign rx_data   = res.rx_data;
    assign rejected  = res.rejected;

    // A completing tick never reports the sequence as still running
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(done_res && busy_res))
        else $error("done and busy reported together");

    // The line is only pulled low while a sequence is running
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && drive_low) |-> busy_res)
        else $error("line driven low outside a sequence");

    // A tick accepted while the output is idle passes the queue, then becomes a valid result
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid) |=> ##1 out_valid)
        else $error("accepted tick did not reach the output");

endmodule
